[rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, register indexes and types of the masked byte pattern
// scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Longest pattern the window can hold and the width of the byte counter
    localparam int PATTERN_MAX = 32;
    localparam int COUNT_WIDTH = 33;

    // The pattern registers carry 32 bytes, so the usable length is the smaller
    localparam int REG_BYTES  = 32;
    localparam int USABLE_LEN = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int SLOT_W     = (USABLE_LEN > 1) ? $clog2(USABLE_LEN) : 1;

    localparam int LEN_W      = 6;
    localparam int ADDR_W     = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_0    = 3'd0,
        REG_PATTERN_1    = 3'd1,
        REG_PATTERN_2    = 3'd2,
        REG_PATTERN_3    = 3'd3,
        REG_CARE_MASK    = 3'd4,
        REG_PATTERN_LEN  = 3'd5,
        REG_REGION_BASE  = 3'd6
    } cfg_index_t;

    // Control broadcast to every window cell
    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

    // One result on its way to the output queue
    typedef struct packed {
        logic  found;
        addr_t match_address;
    } result_t;

endpackage

[rtl/mbps_if.sv]
// ----------------------------------------------------------------------------
// mbps_in_if / mbps_out_if
// Valid/ready channels for the byte stream and for the search results.
// ----------------------------------------------------------------------------
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

[rtl/mbps_cell.sv]
// ----------------------------------------------------------------------------
// mbps_cell
// One slot of the byte window: holds one byte, passes it on to the next
// older slot and compares the byte it takes against its aligned pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] data_in,
    input  logic [7:0] pattern_byte,
    input  logic       care,
    output logic [7:0] data_out,
    output logic       hit
);

    logic [7:0] win_reg;
    logic [7:0] win_next;

    // Compare the byte that enters this slot on the current request
    assign hit      = !care || (data_in == pattern_byte);
    assign data_out = win_reg;

    // Shift in, or drop the window contents at the end of a region
    always_comb
    begin
        win_next = win_reg;
        if (ctrl.advance)
        begin
            win_next = ctrl.clear ? 8'h00 : data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 8'h00;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

[rtl/mbps_out_buf.sv]
// ----------------------------------------------------------------------------
// mbps_out_buf
// Two-entry result queue so the scanner keeps taking bytes while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module mbps_out_buf
    import mbps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    mbps_out_if.source out_ch
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic       pop;

    assign pop                  = out_ch.valid && out_ch.ready;
    assign full                 = (count_reg == 2'd2);
    assign out_ch.valid         = (count_reg != 2'd0);
    assign out_ch.found         = slot0_reg.found;
    assign out_ch.match_address = slot0_reg.match_address;

    // Advance the queue: head in slot 0, second entry in slot 1
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        unique case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = push_data;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[rtl/masked_byte_pattern_scanner.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Searches a byte stream for the first match of a masked pattern.
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock cycle, back to back, and reports the
// first place in each region where the configured pattern matches, with
// wildcards where the care bit is clear, or a not-found result at the end of
// a region without a match. The bytes run through a chain of 32 window cells;
// each cell compares its byte against the pattern byte aligned to it for the
// current length, and all cells are checked in the same cycle as the byte is
// taken, so the result of a byte is pushed into the queue as the byte is
// taken and is offered once it reaches the queue head. A two-entry result queue
// lets bytes keep flowing while a result waits; the input stalls only when both
// entries are held. Write the configuration registers between regions.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    mbps_in_if.sink               in_ch,
    mbps_out_if.source            out_ch
);

    localparam count_t COUNT_MAX = '1;

    // Configuration registers
    logic [63:0] pattern_reg [4];
    logic [31:0] care_reg;
    len_t        length_reg;
    addr_t       base_reg;

    // Region state
    count_t seen_reg;
    count_t seen_next;
    logic   reported_reg;
    logic   reported_next;

    logic [255:0]          pat_flat;
    logic [7:0]            align_byte [USABLE_LEN];
    logic                  align_care [USABLE_LEN];
    logic [7:0]            chain      [USABLE_LEN+1];
    logic [USABLE_LEN-1:0] hits;

    logic       accept;
    logic       full;
    logic       counted;
    count_t     seen_inc;
    count_t     offset;
    logic       len_ok;
    logic       emit_match;
    logic       emit_end;
    cell_ctrl_t ctrl;
    result_t    result;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg[0] <= '0;
            pattern_reg[1] <= '0;
            pattern_reg[2] <= '0;
            pattern_reg[3] <= '0;
            care_reg       <= '0;
            length_reg     <= '0;
            base_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_PATTERN_0:   pattern_reg[0] <= cfg_data;
                REG_PATTERN_1:   pattern_reg[1] <= cfg_data;
                REG_PATTERN_2:   pattern_reg[2] <= cfg_data;
                REG_PATTERN_3:   pattern_reg[3] <= cfg_data;
                REG_CARE_MASK:   care_reg       <= cfg_data[31:0];
                REG_PATTERN_LEN: length_reg     <= cfg_data[LEN_W-1:0];
                REG_REGION_BASE: base_reg       <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Align the pattern to window age: slot a holds pattern byte len-1-a
    assign pat_flat = {pattern_reg[3], pattern_reg[2], pattern_reg[1], pattern_reg[0]};

    always_comb
    begin
        logic [LEN_W-1:0] idx;
        for (int a = 0; a < USABLE_LEN; a++)
        begin
            idx           = length_reg - LEN_W'(1) - LEN_W'(a);
            align_byte[a] = pat_flat[{idx[4:0], 3'b000} +: 8];
            align_care[a] = (LEN_W'(a) < length_reg) && care_reg[idx[4:0]];
        end
    end

    // Window chain: the newest byte enters slot 0
    assign accept    = in_ch.valid && in_ch.ready;
    assign ctrl      = '{advance: accept, clear: in_ch.last_byte};
    assign chain[0]  = in_ch.data_byte;

    for (genvar g = 0; g < USABLE_LEN; g++)
    begin : g_cell
        mbps_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .data_in      (chain[g]),
            .pattern_byte (align_byte[g]),
            .care         (align_care[g]),
            .data_out     (chain[g+1]),
            .hit          (hits[g])
        );
    end

    // Count bytes of the region, saturating at the counter limit
    assign counted  = (seen_reg != COUNT_MAX);
    assign seen_inc = counted ? seen_reg + count_t'(1) : seen_reg;
    assign offset   = seen_inc - count_t'(length_reg);
    assign len_ok   = (length_reg != '0) && (length_reg <= LEN_W'(USABLE_LEN));

    // Decide the result of the current byte
    assign emit_match = !reported_reg && counted && len_ok
                        && (seen_inc >= count_t'(length_reg)) && (&hits);
    assign emit_end   = in_ch.last_byte && !reported_reg && !emit_match;

    assign result.found         = emit_match;
    assign result.match_address = emit_match ? base_reg + ADDR_W'(offset) : '0;

    always_comb
    begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (accept)
        begin
            if (in_ch.last_byte)
            begin
                seen_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                seen_next     = seen_inc;
                reported_next = reported_reg || emit_match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    // Hold results until the sink takes them
    assign in_ch.ready = !full;

    mbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (emit_match || emit_end)),
        .push_data (result),
        .full      (full),
        .out_ch    (out_ch)
    );

endmodule
